// ===== design/tss_pkg.sv =====
`timescale 1ns / 1ps

package tss_pkg;

    // Board count and saturation limit of word offsets
    localparam int BOARDS    = 6;
    localparam int NTAGS     = 6;
    localparam int MAX_WORDS = 65536;

    // Field and bus widths
    localparam int WORD_W    = 32;
    localparam int TAG_W     = 64;
    localparam int POS_W     = 17;
    localparam int BOARD_W   = 3;
    localparam int ADDR_W    = 6;
    localparam int DATA_W    = 64;
    localparam int REG_IDX_W = 3;

    // Result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // Largest word offset
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_WORDS);

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_BOARD_TAG_0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BOARD_TAG_5 = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ACTIVE_MASK = 3'd6;

    // Record kinds
    typedef enum logic [1:0] {
        KIND_SEGMENT   = 2'd0,
        KIND_DUPLICATE = 2'd1,
        KIND_END       = 2'd2
    } kind_t;

    // One result word
    typedef struct packed {
        kind_t              kind;
        logic [BOARD_W-1:0] board;
        logic [POS_W-1:0]   start;
        logic [POS_W-1:0]   length;
        logic               last;
    } record_t;

    // Configuration seen by the scanner
    typedef struct packed {
        logic [NTAGS-1:0][TAG_W-1:0] tag;
        logic [NTAGS-1:0]            active;
    } cfg_t;

    // Records handed to the result queue in one cycle
    typedef struct packed {
        logic [1:0] count;
        record_t    first;
        record_t    second;
    } push_t;

endpackage

// ===== design/tagged_subevent_segmenter.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Word
// data      in         data_valid/stall     data_word, end_of_subevent
// result    out        result_valid/stall   record_kind, board_index, segment_start,
//                                           segment_length, last_of_subevent
// config    in         APB write, 64 bits   board_tag_0..5 at 8*i, active_mask at 48
//
// One data word is taken per cycle while data_stall is low.  A word waits in the input
// register until the queue has room for two records, and its records are then written
// into the queue, whose head drives the outputs.  Records leave through a four-entry
// queue at one per cycle while result_stall is low.  Input stalls while a word waits in
// the input register and the queue holds more than two records.  Reset clears control
// state and configuration at once, not the stored words; there is no clearing pass.

module tagged_subevent_segmenter
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          data_valid,
    output logic                          data_stall,
    input  logic [31:0]                   data_word,
    input  logic                          end_of_subevent,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [1:0]                    record_kind,
    output logic [2:0]                    board_index,
    output logic [16:0]                   segment_start,
    output logic [16:0]                   segment_length,
    output logic                          last_of_subevent,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tss_pkg::ADDR_W-1:0]    paddr,
    input  logic [tss_pkg::DATA_W-1:0]    pwdata,
    output logic [tss_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    tss_pkg::cfg_t     cfg;
    tss_pkg::push_t    push;
    tss_pkg::record_t  head;
    logic              room2;

    // Configuration registers
    tss_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Tag scanner
    tss_seg_core u_core
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .data_valid      (data_valid),
        .data_stall      (data_stall),
        .data_word       (data_word),
        .end_of_subevent (end_of_subevent),
        .cfg             (cfg),
        .room2           (room2),
        .push            (push)
    );

    // Result queue
    tss_result_fifo u_fifo
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room2        (room2),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .head         (head)
    );

    assign record_kind      = head.kind;
    assign board_index      = head.board;
    assign segment_start    = head.start;
    assign segment_length   = head.length;
    assign last_of_subevent = head.last;

endmodule

// ===== design/tss_cfg_regs.sv =====
`timescale 1ns / 1ps

module tss_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tss_pkg::ADDR_W-1:0]    paddr,
    input  logic [tss_pkg::DATA_W-1:0]    pwdata,
    output logic [tss_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output tss_pkg::cfg_t                 cfg
);

    logic [tss_pkg::NTAGS-1:0][tss_pkg::TAG_W-1:0] tag_reg;
    logic [tss_pkg::NTAGS-1:0]                     active_reg;
    logic [tss_pkg::REG_IDX_W-1:0]                 reg_index;
    logic                                          write_en;

    // Registers sit on 8-byte boundaries
    assign reg_index = paddr[tss_pkg::ADDR_W-1:3];
    assign write_en  = psel && penable && pwrite;
    assign pready    = 1'b1;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg    <= '0;
            active_reg <= '0;
        end
        else if (write_en)
        begin
            unique case (reg_index) inside
                [tss_pkg::REG_BOARD_TAG_0:tss_pkg::REG_BOARD_TAG_5]:
                    tag_reg[reg_index] <= pwdata[tss_pkg::TAG_W-1:0];
                tss_pkg::REG_ACTIVE_MASK:
                    active_reg <= pwdata[tss_pkg::NTAGS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        unique case (reg_index) inside
            [tss_pkg::REG_BOARD_TAG_0:tss_pkg::REG_BOARD_TAG_5]:
                prdata = tag_reg[reg_index];
            tss_pkg::REG_ACTIVE_MASK:
                prdata = tss_pkg::DATA_W'(active_reg);
            default:
                prdata = '0;
        endcase
    end

    assign cfg.tag    = tag_reg;
    assign cfg.active = active_reg;

endmodule

// ===== design/tss_seg_core.sv =====
`timescale 1ns / 1ps

module tss_seg_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          data_valid,
    output logic                          data_stall,
    input  logic [tss_pkg::WORD_W-1:0]    data_word,
    input  logic                          end_of_subevent,
    input  tss_pkg::cfg_t                 cfg,
    input  logic                          room2,
    output tss_pkg::push_t                push
);

    // Input register
    logic                          in_valid_reg;
    logic [tss_pkg::WORD_W-1:0]    word_reg;
    logic                          last_reg;

    // Scan state
    logic [tss_pkg::WORD_W-1:0]    held_word_reg,   held_word_next;
    logic                          held_valid_reg,  held_valid_next;
    logic [tss_pkg::POS_W-1:0]     word_pos_reg,    word_pos_next;
    logic                          open_valid_reg,  open_valid_next;
    logic [tss_pkg::BOARD_W-1:0]   open_board_reg,  open_board_next;
    logic [tss_pkg::POS_W-1:0]     open_start_reg,  open_start_next;
    logic [tss_pkg::BOARDS-1:0]    boards_seen_reg, boards_seen_next;

    logic                          accept;
    logic                          advance;
    logic [tss_pkg::TAG_W-1:0]     pair;
    logic [tss_pkg::BOARDS-1:0]    hit;
    logic [tss_pkg::BOARDS-1:0]    first_hit;
    logic [tss_pkg::BOARD_W-1:0]   hit_board;
    logic                          matched;
    logic                          duplicate;
    logic [tss_pkg::POS_W-1:0]     next_pos;
    logic [tss_pkg::POS_W-1:0]     tag_pos;
    logic                          close_a;
    logic                          close_b;
    logic                          open1_valid;
    logic [tss_pkg::BOARD_W-1:0]   open1_board;
    logic [tss_pkg::POS_W-1:0]     open1_start;
    tss_pkg::record_t              rec_a;
    tss_pkg::record_t              rec_b;
    tss_pkg::record_t              rec_dup;
    tss_pkg::record_t              rec_end;
    tss_pkg::record_t              second;
    logic                          second_valid;
    tss_pkg::push_t                result;

    // A held word is processed once the queue can take two records
    assign advance    = in_valid_reg && room2;
    assign data_stall = in_valid_reg && !room2;
    assign accept     = data_valid && !data_stall;

    // Tag compare over all boards, lowest board wins
    always_comb
    begin
        pair = {word_reg, held_word_reg};
        hit  = '0;
        for (int b = 0; b < tss_pkg::BOARDS; b++)
        begin
            hit[b] = cfg.active[b] && (cfg.tag[b] != '0) && (cfg.tag[b] == pair);
        end
        first_hit = hit & (~hit + 1'b1);
        hit_board = '0;
        for (int b = 0; b < tss_pkg::BOARDS; b++)
        begin
            if (first_hit[b])
            begin
                hit_board = tss_pkg::BOARD_W'(b);
            end
        end
        matched   = held_valid_reg && (hit != '0);
        duplicate = matched && ((first_hit & boards_seen_reg) != '0);
    end

    // Word offsets
    assign next_pos = (word_pos_reg == tss_pkg::MAX_POS) ? word_pos_reg
                                                         : word_pos_reg + 1'b1;
    assign tag_pos  = (word_pos_reg != '0) ? word_pos_reg - 1'b1 : '0;

    // Records for the open segment closed by a tag, a repeated tag, and the end
    always_comb
    begin
        close_a = matched && open_valid_reg;

        open1_valid = matched ? !duplicate : open_valid_reg;
        open1_board = matched ? hit_board  : open_board_reg;
        open1_start = matched ? next_pos   : open_start_reg;
        close_b     = last_reg && open1_valid;

        rec_a        = '0;
        rec_a.kind   = tss_pkg::KIND_SEGMENT;
        rec_a.board  = open_board_reg;
        rec_a.start  = open_start_reg;
        rec_a.length = (tag_pos >= open_start_reg) ? tag_pos - open_start_reg : '0;

        rec_b        = '0;
        rec_b.kind   = tss_pkg::KIND_SEGMENT;
        rec_b.board  = open1_board;
        rec_b.start  = open1_start;
        rec_b.length = (next_pos >= open1_start) ? next_pos - open1_start : '0;

        rec_dup       = '0;
        rec_dup.kind  = tss_pkg::KIND_DUPLICATE;
        rec_dup.board = hit_board;

        rec_end      = '0;
        rec_end.kind = tss_pkg::KIND_END;

        // A repeated tag opens nothing, so it never meets an end close
        second_valid = duplicate || close_b;
        second       = duplicate ? rec_dup : rec_b;

        result        = '0;
        result.first  = rec_end;
        result.second = second;
        if (close_a)
        begin
            result.first = rec_a;
            result.count = second_valid ? 2'd2 : 2'd1;
        end
        else if (second_valid)
        begin
            result.first = second;
            result.count = 2'd1;
        end
        else if (last_reg)
        begin
            result.count = 2'd1;
        end

        // Mark the final record of the subevent
        if (last_reg)
        begin
            if (result.count == 2'd2)
            begin
                result.second.last = 1'b1;
            end
            else
            begin
                result.first.last = 1'b1;
            end
        end

        push       = result;
        push.count = advance ? result.count : 2'd0;
    end

    // Next scan state
    always_comb
    begin
        held_word_next   = held_word_reg;
        held_valid_next  = held_valid_reg;
        boards_seen_next = boards_seen_reg;
        if (matched)
        begin
            held_valid_next = 1'b0;
            if (!duplicate)
            begin
                boards_seen_next = boards_seen_reg | first_hit;
            end
        end
        else if (!last_reg)
        begin
            held_word_next  = word_reg;
            held_valid_next = 1'b1;
        end
        word_pos_next   = next_pos;
        open_valid_next = open1_valid;
        open_board_next = open1_board;
        open_start_next = open1_start;

        // Everything starts afresh after the last word
        if (last_reg)
        begin
            held_word_next   = '0;
            held_valid_next  = 1'b0;
            word_pos_next    = '0;
            open_valid_next  = 1'b0;
            open_board_next  = '0;
            open_start_next  = '0;
            boards_seen_next = '0;
        end
    end

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= data_word;
            last_reg <= end_of_subevent;
        end
    end

    // Scan state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_word_reg   <= '0;
            held_valid_reg  <= 1'b0;
            word_pos_reg    <= '0;
            open_valid_reg  <= 1'b0;
            open_board_reg  <= '0;
            open_start_reg  <= '0;
            boards_seen_reg <= '0;
        end
        else if (advance)
        begin
            held_word_reg   <= held_word_next;
            held_valid_reg  <= held_valid_next;
            word_pos_reg    <= word_pos_next;
            open_valid_reg  <= open_valid_next;
            open_board_reg  <= open_board_next;
            open_start_reg  <= open_start_next;
            boards_seen_reg <= boards_seen_next;
        end
    end

endmodule

// ===== design/tss_result_fifo.sv =====
`timescale 1ns / 1ps

module tss_result_fifo
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  tss_pkg::push_t                  push,
    output logic                            room2,
    output logic                            result_valid,
    input  logic                            result_stall,
    output tss_pkg::record_t                head
);

    tss_pkg::record_t                mem_reg [tss_pkg::FIFO_DEPTH];
    logic [tss_pkg::FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [tss_pkg::FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [tss_pkg::FIFO_CNT_W-1:0]  count_reg,  count_next;
    logic [tss_pkg::FIFO_PTR_W-1:0]  wr_ptr_plus1;
    logic                            pop;

    assign result_valid = (count_reg != '0);
    assign pop          = result_valid && !result_stall;
    assign room2        = (count_reg <= tss_pkg::FIFO_CNT_W'(tss_pkg::FIFO_DEPTH - 2));
    assign head         = mem_reg[rd_ptr_reg];
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    // Pointer and fill arithmetic
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + tss_pkg::FIFO_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + tss_pkg::FIFO_PTR_W'(pop);
        count_next  = count_reg + tss_pkg::FIFO_CNT_W'(push.count)
                      - tss_pkg::FIFO_CNT_W'(pop);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Record storage, up to two writes a cycle
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= push.second;
        end
    end

endmodule

// ===== design/tss_checker.sv =====
`timescale 1ns / 1ps

module tss_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [1:0]  record_kind,
    input  logic [2:0]  board_index,
    input  logic [16:0] segment_start,
    input  logic [16:0] segment_length,
    input  logic        last_of_subevent
);

    // No record kind outside the three defined ones
    a_kind_defined: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (record_kind == tss_pkg::KIND_SEGMENT)
                      || (record_kind == tss_pkg::KIND_DUPLICATE)
                      || (record_kind == tss_pkg::KIND_END))
        else $error("undefined record kind");

    // An end marker is always the last record and carries no segment
    a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (record_kind == tss_pkg::KIND_END)) |->
            (last_of_subevent && (board_index == '0) && (segment_start == '0)
             && (segment_length == '0)))
        else $error("malformed end marker");

    // A repeated tag carries no segment offsets
    a_duplicate_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (record_kind == tss_pkg::KIND_DUPLICATE)) |->
            ((segment_start == '0) && (segment_length == '0)))
        else $error("duplicate record with segment offsets");

    // Board numbers stay below the board count
    a_board_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (board_index < 3'(tss_pkg::BOARDS)))
        else $error("board index out of range");

    // A stalled record is held
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=>
            (result_valid && $stable(record_kind) && $stable(board_index)
             && $stable(segment_start) && $stable(segment_length)
             && $stable(last_of_subevent)))
        else $error("stalled record changed");

endmodule

bind tagged_subevent_segmenter tss_checker u_tss_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .record_kind      (record_kind),
    .board_index      (board_index),
    .segment_start    (segment_start),
    .segment_length   (segment_length),
    .last_of_subevent (last_of_subevent)
);
